// ----- rtl/core/pdc_pkg.sv -----
package pdc_pkg;

  localparam int AXES       = 8;
  localparam int AXIS_W     = $clog2(AXES);
  localparam int SAMPLE_W   = 10;
  localparam int OFF_W      = SAMPLE_W + 1;
  localparam int SUM_W      = 2 * SAMPLE_W;
  localparam int PTS_W      = 10;
  localparam int TOL_W      = 10;
  localparam int WAIT_W     = 16;
  localparam int TIME_W     = 32;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int DIV_STEP_W = $clog2(SUM_W + 1);

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_TOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_MS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS     = 2'd3;

  localparam logic [TOL_W-1:0]  CENTER_TOL_RST = 10'd20;
  localparam logic [TOL_W-1:0]  SPREAD_TOL_RST = 10'd10;
  localparam logic [WAIT_W-1:0] WAIT_MS_RST    = 16'd1000;
  localparam logic [PTS_W-1:0]  POINTS_RST     = 10'd100;

  typedef struct packed {
    logic capture;
    logic load;
    logic check;
    logic decide;
    logic commit;
    logic emit;
  } pdc_cmd_t;

  typedef struct packed {
    logic is_center;
    logic need_div;
    logic div_done;
    logic out_free;
  } pdc_sts_t;

endpackage

// ----- rtl/core/pdc_div.sv -----
module pdc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pdc_pkg::SUM_W-1:0]   dividend_i,
  input  logic [pdc_pkg::PTS_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [pdc_pkg::SUM_W-1:0]   quotient_o
);

  logic                            busy_q;
  logic                            done_q;
  logic [pdc_pkg::DIV_STEP_W-1:0]  step_q;
  logic [pdc_pkg::SUM_W-1:0]       dvd_q, dvd_d;
  logic [pdc_pkg::PTS_W:0]         rem_q, rem_d;
  logic [pdc_pkg::PTS_W-1:0]       dvs_q;
  logic [pdc_pkg::PTS_W:0]         rem_sh;
  logic                            ge;

  always_comb begin
    rem_sh = {rem_q[pdc_pkg::PTS_W-1:0], dvd_q[pdc_pkg::SUM_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
    dvd_d  = {dvd_q[pdc_pkg::SUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= pdc_pkg::DIV_STEP_W'(pdc_pkg::SUM_W);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == pdc_pkg::DIV_STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ----- rtl/core/pdc_ctrl.sv -----
module pdc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pdc_pkg::pdc_sts_t  sts_i,
  output pdc_pkg::pdc_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = sts_i.is_center ? S_OUT : S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = sts_i.need_div ? S_DIV : S_OUT;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.commit = 1'b1;
          state_d      = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ----- rtl/core/pdc_datapath.sv -----
module pdc_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pdc_pkg::pdc_cmd_t                cmd_i,
  output pdc_pkg::pdc_sts_t                sts_o,
  input  logic                             cfg_we_i,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pdc_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                             mode_i,
  input  logic [pdc_pkg::AXIS_W-1:0]       axis_i,
  input  logic [pdc_pkg::SAMPLE_W-1:0]     value_i,
  input  logic [pdc_pkg::TIME_W-1:0]       now_ms_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [pdc_pkg::AXIS_W-1:0]       axis_out_o,
  output logic signed [pdc_pkg::OFF_W-1:0] offset_o,
  output logic                             stable_o,
  output logic                             committed_o
);

  localparam int SW = pdc_pkg::SAMPLE_W;
  localparam int OW = pdc_pkg::OFF_W;

  // configuration
  logic [pdc_pkg::TOL_W-1:0]  ctol_q, stol_q;
  logic [pdc_pkg::WAIT_W-1:0] wait_q;
  logic [pdc_pkg::PTS_W-1:0]  pts_q;

  // per-axis state
  logic [SW-1:0]                center_q [pdc_pkg::AXES];
  logic [OW-1:0]                held_q   [pdc_pkg::AXES];
  logic [SW-1:0]                wmin_q   [pdc_pkg::AXES];
  logic [SW-1:0]                wmax_q   [pdc_pkg::AXES];
  logic [pdc_pkg::SUM_W-1:0]    wsum_q   [pdc_pkg::AXES];
  logic [pdc_pkg::PTS_W-1:0]    wcnt_q   [pdc_pkg::AXES];
  logic [pdc_pkg::TIME_W-1:0]   wstart_q [pdc_pkg::AXES];
  logic                         started_q;

  // captured beat
  logic                         mode_q;
  logic [pdc_pkg::AXIS_W-1:0]   axis_q;
  logic [SW-1:0]                value_q;
  logic [pdc_pkg::TIME_W-1:0]   now_q;

  // working copy of the addressed axis
  logic [SW-1:0]                c_q, mn_q, mx_q;
  logic [OW-1:0]                held_w_q;
  logic [pdc_pkg::SUM_W-1:0]    sum_q;
  logic [pdc_pkg::PTS_W-1:0]    cnt_q;
  logic [pdc_pkg::TIME_W-1:0]   start_q;

  // check stage
  logic [SW-1:0]                mnn_q, mxn_q, dist_q, spread_q;
  logic [pdc_pkg::TIME_W-1:0]   elapsed_q;
  logic [OW-1:0]                lin_q;
  logic [SW-1:0]                mnn_d, mxn_d, dist_d;

  // result and output
  logic [OW-1:0]                res_off_q;
  logic                         res_stable_q, res_commit_q;
  logic                         out_valid_q;
  logic [pdc_pkg::AXIS_W-1:0]   out_axis_q;
  logic [OW-1:0]                out_off_q;
  logic                         out_stable_q, out_commit_q;

  // decide stage
  logic                         clr_center;
  logic                         clear_all;
  logic                         stable_d, timed_d, commit_d;
  logic [pdc_pkg::SUM_W-1:0]    sum_d;
  logic [pdc_pkg::PTS_W-1:0]    cnt_d, pts_eff;
  logic                         div_done;
  logic [pdc_pkg::SUM_W-1:0]    quot;
  logic [OW-1:0]                avg_off;

  always_comb begin
    clr_center = !started_q || (value_q != center_q[axis_q]);
    clear_all  = cmd_i.load && (mode_q ? !started_q : clr_center);

    mnn_d  = (value_q < mn_q) ? value_q : mn_q;
    mxn_d  = (value_q > mx_q) ? value_q : mx_q;
    dist_d = (value_q >= c_q) ? value_q - c_q : c_q - value_q;

    pts_eff  = (pts_q == '0) ? pdc_pkg::PTS_W'(1) : pts_q;
    stable_d = (dist_q <= ctol_q) && (spread_q <= stol_q);
    timed_d  = elapsed_q >= pdc_pkg::TIME_W'(wait_q);
    sum_d    = sum_q + pdc_pkg::SUM_W'(value_q);
    cnt_d    = cnt_q + 1'b1;
    commit_d = stable_d && timed_d && (cnt_d >= pts_eff);

    avg_off  = {1'b0, c_q} - quot[OW-1:0];
  end

  pdc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.decide && commit_d),
    .dividend_i (sum_d),
    .divisor_i  (pts_eff),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctol_q <= pdc_pkg::CENTER_TOL_RST;
      stol_q <= pdc_pkg::SPREAD_TOL_RST;
      wait_q <= pdc_pkg::WAIT_MS_RST;
      pts_q  <= pdc_pkg::POINTS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pdc_pkg::REG_CENTER_TOL: ctol_q <= cfg_data_i[pdc_pkg::TOL_W-1:0];
        pdc_pkg::REG_SPREAD_TOL: stol_q <= cfg_data_i[pdc_pkg::TOL_W-1:0];
        pdc_pkg::REG_WAIT_MS:    wait_q <= cfg_data_i[pdc_pkg::WAIT_W-1:0];
        pdc_pkg::REG_POINTS:     pts_q  <= cfg_data_i[pdc_pkg::PTS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      for (int a = 0; a < pdc_pkg::AXES; a++) begin
        center_q[a] <= '0;
        held_q[a]   <= '0;
        wmin_q[a]   <= pdc_pkg::SAMPLE_MAX;
        wmax_q[a]   <= '0;
        wsum_q[a]   <= '0;
        wcnt_q[a]   <= '0;
        wstart_q[a] <= '0;
      end
    end else begin
      if (clear_all) begin
        started_q <= 1'b1;
        for (int a = 0; a < pdc_pkg::AXES; a++) begin
          held_q[a]   <= '0;
          wmin_q[a]   <= pdc_pkg::SAMPLE_MAX;
          wmax_q[a]   <= '0;
          wsum_q[a]   <= '0;
          wcnt_q[a]   <= '0;
          wstart_q[a] <= now_q;
        end
      end
      if (cmd_i.load && !mode_q) begin
        center_q[axis_q] <= value_q;
      end
      if (cmd_i.decide) begin
        if (!stable_d || commit_d) begin
          wmin_q[axis_q]   <= pdc_pkg::SAMPLE_MAX;
          wmax_q[axis_q]   <= '0;
          wsum_q[axis_q]   <= '0;
          wcnt_q[axis_q]   <= '0;
          wstart_q[axis_q] <= now_q;
        end else begin
          wmin_q[axis_q] <= mnn_q;
          wmax_q[axis_q] <= mxn_q;
          if (timed_d) begin
            wsum_q[axis_q] <= sum_d;
            wcnt_q[axis_q] <= cnt_d;
          end
        end
      end
      if (cmd_i.commit) begin
        held_q[axis_q] <= avg_off;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= mode_i;
      axis_q  <= axis_i;
      value_q <= value_i;
      now_q   <= now_ms_i;
    end
    if (cmd_i.load) begin
      c_q <= center_q[axis_q];
      if (!started_q) begin
        held_w_q <= '0;
        mn_q     <= pdc_pkg::SAMPLE_MAX;
        mx_q     <= '0;
        sum_q    <= '0;
        cnt_q    <= '0;
        start_q  <= now_q;
      end else begin
        held_w_q <= held_q[axis_q];
        mn_q     <= wmin_q[axis_q];
        mx_q     <= wmax_q[axis_q];
        sum_q    <= wsum_q[axis_q];
        cnt_q    <= wcnt_q[axis_q];
        start_q  <= wstart_q[axis_q];
      end
      res_off_q    <= clr_center ? '0 : held_q[axis_q];
      res_stable_q <= 1'b0;
      res_commit_q <= 1'b0;
    end
    if (cmd_i.check) begin
      mnn_q     <= mnn_d;
      mxn_q     <= mxn_d;
      dist_q    <= dist_d;
      spread_q  <= mxn_d - mnn_d;
      elapsed_q <= now_q - start_q;
      lin_q     <= {1'b0, c_q} - {1'b0, value_q};
    end
    if (cmd_i.decide) begin
      res_off_q    <= stable_d ? lin_q : held_w_q;
      res_stable_q <= stable_d;
      res_commit_q <= 1'b0;
    end
    if (cmd_i.commit) begin
      res_off_q    <= avg_off;
      res_stable_q <= 1'b1;
      res_commit_q <= 1'b1;
    end
    if (cmd_i.emit) begin
      out_axis_q   <= axis_q;
      out_off_q    <= res_off_q;
      out_stable_q <= res_stable_q;
      out_commit_q <= res_commit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.is_center = !mode_q;
  assign sts_o.need_div  = commit_d;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign axis_out_o  = out_axis_q;
  assign offset_o    = $signed(out_off_q);
  assign stable_o    = out_stable_q;
  assign committed_o = out_commit_q;

endmodule

// ----- rtl/core/per_axis_drift_compensator.sv -----
// Per-axis drift compensator for eight 10-bit sensor axes. Each input beat
// either sets an axis center (mode 0) or delivers a raw sample (mode 1) with
// a millisecond timestamp, and yields exactly one output beat carrying the
// axis, the offset, and stable/committed flags. A changed center clears the
// windows and held offsets of all axes. One beat is processed at a time: a
// center set passes through load to the output register, a sample through
// load, check and decide, and a sample that commits a new average also
// through the shared restoring divider (one quotient bit per cycle over
// the 20-bit window sum). The next beat is accepted once its predecessor
// has been written to the output register. The output register lets the
// next beat be accepted while a result still waits downstream. Configuration
// is written through cfg_we_i / cfg_index_i / cfg_data_i; the user must do so
// only while no beat is in flight, as the block itself does not enforce it.
module per_axis_drift_compensator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pdc_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             mode_i,
  input  logic [pdc_pkg::AXIS_W-1:0]       axis_i,
  input  logic [pdc_pkg::SAMPLE_W-1:0]     value_i,
  input  logic [pdc_pkg::TIME_W-1:0]       now_ms_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [pdc_pkg::AXIS_W-1:0]       axis_out_o,
  output logic signed [pdc_pkg::OFF_W-1:0] offset_o,
  output logic                             stable_o,
  output logic                             committed_o
);

  pdc_pkg::pdc_cmd_t cmd;
  pdc_pkg::pdc_sts_t sts;

  pdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pdc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mode_i      (mode_i),
    .axis_i      (axis_i),
    .value_i     (value_i),
    .now_ms_i    (now_ms_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .axis_out_o  (axis_out_o),
    .offset_o    (offset_o),
    .stable_o    (stable_o),
    .committed_o (committed_o)
  );

`ifndef SYNTH
  a_commit_is_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && committed_o |-> stable_o)
    else $error("committed beat not flagged stable");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a beat");

  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("result emitted over an unaccepted output beat");
`endif

endmodule

// ----- verif/tb_per_axis_drift_compensator.sv -----
`timescale 1ns / 1ps

module tb_per_axis_drift_compensator;

  localparam logic MODE_CENTER = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;
  localparam int   QUIET_LIMIT = 1000;
  localparam int   TAIL_CYCLES = 40;
  localparam int   SMAX        = int'(pdc_pkg::SAMPLE_MAX);

  typedef struct packed {
    logic                         mode;
    logic [pdc_pkg::AXIS_W-1:0]   axis;
    logic [pdc_pkg::SAMPLE_W-1:0] value;
    logic [pdc_pkg::TIME_W-1:0]   stamp;
  } beat_t;

  typedef struct packed {
    logic [pdc_pkg::AXIS_W-1:0]       axis;
    logic signed [pdc_pkg::OFF_W-1:0] offset;
    logic                             stable;
    logic                             committed;
  } drift_res_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [pdc_pkg::CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [pdc_pkg::CFG_W-1:0]        cfg_data_i = '0;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  logic                             mode_i = 1'b0;
  logic [pdc_pkg::AXIS_W-1:0]       axis_i = '0;
  logic [pdc_pkg::SAMPLE_W-1:0]     value_i = '0;
  logic [pdc_pkg::TIME_W-1:0]       now_ms_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic [pdc_pkg::AXIS_W-1:0]       axis_out_o;
  logic signed [pdc_pkg::OFF_W-1:0] offset_o;
  logic                             stable_o;
  logic                             committed_o;

  per_axis_drift_compensator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .axis_i      (axis_i),
    .value_i     (value_i),
    .now_ms_i    (now_ms_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .axis_out_o  (axis_out_o),
    .offset_o    (offset_o),
    .stable_o    (stable_o),
    .committed_o (committed_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [pdc_pkg::TOL_W-1:0]        c_ctol = pdc_pkg::CENTER_TOL_RST;
  logic [pdc_pkg::TOL_W-1:0]        c_stol = pdc_pkg::SPREAD_TOL_RST;
  logic [pdc_pkg::WAIT_W-1:0]       c_wait = pdc_pkg::WAIT_MS_RST;
  logic [pdc_pkg::PTS_W-1:0]        c_pts  = pdc_pkg::POINTS_RST;
  logic [pdc_pkg::SAMPLE_W-1:0]     m_center [pdc_pkg::AXES];
  logic signed [pdc_pkg::OFF_W-1:0] m_held   [pdc_pkg::AXES];
  logic [pdc_pkg::SAMPLE_W-1:0]     m_lo     [pdc_pkg::AXES];
  logic [pdc_pkg::SAMPLE_W-1:0]     m_hi     [pdc_pkg::AXES];
  int                               m_sum    [pdc_pkg::AXES];
  int                               m_cnt    [pdc_pkg::AXES];
  logic [pdc_pkg::TIME_W-1:0]       m_t0     [pdc_pkg::AXES];
  logic                             m_armed;

  beat_t      pending[$];
  drift_res_t due_results[$];
  beat_t      nxt;
  drift_res_t want;
  logic       in_took = 1'b0;
  logic       out_took = 1'b0;
  logic       pace_on = 1'b1;
  int         gap_left = 0;
  int         hold_left = 0;
  int         quiet_cycles = 0;
  int         errors = 0;
  int         n_beats = 0;
  int         n_results = 0;
  int         n_commits = 0;
  int         n_unstable = 0;
  int         n_writes = 0;
  logic [pdc_pkg::TIME_W-1:0]   ms_clock = '0;
  logic [pdc_pkg::SAMPLE_W-1:0] aim [pdc_pkg::AXES];

  function automatic void restart_axis(int a, logic [pdc_pkg::TIME_W-1:0] t);
    m_lo[a]  = pdc_pkg::SAMPLE_MAX;
    m_hi[a]  = '0;
    m_sum[a] = 0;
    m_cnt[a] = 0;
    m_t0[a]  = t;
  endfunction

  function automatic void clear_axes(logic [pdc_pkg::TIME_W-1:0] t);
    for (int a = 0; a < pdc_pkg::AXES; a++) begin
      restart_axis(a, t);
      m_held[a] = '0;
    end
    m_armed = 1'b1;
  endfunction

  function automatic drift_res_t predict_offset(beat_t b);
    drift_res_t                 r;
    int                         a;
    int                         c;
    int                         v;
    int                         dev;
    int                         pts;
    logic [pdc_pkg::TIME_W-1:0] dt;
    a = int'(b.axis);
    c = int'(m_center[a]);
    v = int'(b.value);
    pts = (c_pts == 0) ? 1 : int'(c_pts);
    r.axis = b.axis;
    r.offset = '0;
    r.stable = 1'b0;
    r.committed = 1'b0;
    if (b.mode == MODE_CENTER) begin
      if (!m_armed || b.value != m_center[a]) clear_axes(b.stamp);
      m_center[a] = b.value;
      r.offset = m_held[a];
    end else begin
      if (!m_armed) clear_axes(b.stamp);
      if (b.value < m_lo[a]) m_lo[a] = b.value;
      if (b.value > m_hi[a]) m_hi[a] = b.value;
      dev = (v > c) ? v - c : c - v;
      r.stable = (dev <= int'(c_ctol)) &&
                 (int'(m_hi[a]) - int'(m_lo[a]) <= int'(c_stol));
      if (!r.stable) begin
        r.offset = m_held[a];
        restart_axis(a, b.stamp);
      end else begin
        r.offset = pdc_pkg::OFF_W'(c - v);
        dt = b.stamp - m_t0[a];
        if (dt >= pdc_pkg::TIME_W'(c_wait)) begin
          m_sum[a] += v;
          m_cnt[a]++;
          if (m_cnt[a] >= pts) begin
            m_held[a] = pdc_pkg::OFF_W'(c - m_sum[a] / pts);
            r.offset = m_held[a];
            r.committed = 1'b1;
            restart_axis(a, b.stamp);
          end
        end
      end
    end
    return r;
  endfunction

  // input side: beats change on the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending.size() != 0) begin
        nxt = pending.pop_front();
        mode_i     <= nxt.mode;
        axis_i     <= nxt.axis;
        value_i    <= nxt.value;
        now_ms_i   <= nxt.stamp;
        in_valid_i <= 1'b1;
        gap_left = pace_on ? $urandom_range(0, 3) : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side stall
  always @(negedge clk_i) begin
    if (out_took) hold_left = pace_on ? $urandom_range(0, 3) : 0;
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      if (out_valid_o) hold_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    in_took  <= rst_ni && in_valid_i && !in_stall_o;
    out_took <= rst_ni && out_valid_o && !out_stall_i;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (due_results.size() == 0) begin
        $error("result with nothing pending: axis_out %0d offset %0d", axis_out_o, offset_o);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (axis_out_o !== want.axis) begin
          $error("axis_out: expected %0d, got %0d", want.axis, axis_out_o);
          errors++;
        end
        if (offset_o !== want.offset) begin
          $error("offset: expected %0d, got %0d", want.offset, offset_o);
          errors++;
        end
        if (stable_o !== want.stable) begin
          $error("stable: expected %0b, got %0b", want.stable, stable_o);
          errors++;
        end
        if (committed_o !== want.committed) begin
          $error("committed: expected %0b, got %0b", want.committed, committed_o);
          errors++;
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      want = predict_offset({mode_i, axis_i, value_i, now_ms_i});
      n_beats++;
      if (want.committed) n_commits++;
      if (want.stable == 1'b0 && mode_i == MODE_SAMPLE) n_unstable++;
      due_results.push_back(want);
    end
    if ((rst_ni && in_valid_i && !in_stall_o) || (rst_ni && out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: %0d cycles without a beat, %0d results pending",
               quiet_cycles, due_results.size());
      $display("tb_per_axis_drift_compensator NOT OK");
      $finish;
    end
  end

  task automatic add_beat(logic mode, int axis, int value,
                          logic [pdc_pkg::TIME_W-1:0] stamp);
    beat_t b;
    b.mode  = mode;
    b.axis  = pdc_pkg::AXIS_W'(axis);
    b.value = pdc_pkg::SAMPLE_W'(value);
    b.stamp = stamp;
    pending.push_back(b);
  endtask

  task automatic drain();
    while (pending.size() != 0 || in_valid_i || due_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [pdc_pkg::CFG_IDX_W-1:0] idx, int val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= pdc_pkg::CFG_W'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pdc_pkg::REG_CENTER_TOL: c_ctol = pdc_pkg::TOL_W'(val);
      pdc_pkg::REG_SPREAD_TOL: c_stol = pdc_pkg::TOL_W'(val);
      pdc_pkg::REG_WAIT_MS:    c_wait = pdc_pkg::WAIT_W'(val);
      pdc_pkg::REG_POINTS:     c_pts  = pdc_pkg::PTS_W'(val);
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic set_regs(int ctol, int stol, int wait_ms, int pts);
    write_reg(pdc_pkg::REG_CENTER_TOL, ctol);
    write_reg(pdc_pkg::REG_SPREAD_TOL, stol);
    write_reg(pdc_pkg::REG_WAIT_MS, wait_ms);
    write_reg(pdc_pkg::REG_POINTS, pts);
  endtask

  // mostly samples close to each axis center, with noise, time jumps and re-centering
  task automatic fill_random(int n);
    int a;
    int r;
    int span;
    int v;
    for (int k = 0; k < pdc_pkg::AXES; k++) begin
      aim[k] = pdc_pkg::SAMPLE_W'($urandom_range(0, SMAX));
      ms_clock += $urandom_range(0, 3);
      add_beat(MODE_CENTER, k, int'(aim[k]), ms_clock);
    end
    for (int k = 0; k < n; k++) begin
      a = int'($urandom_range(0, pdc_pkg::AXES - 1));
      r = int'($urandom_range(0, 99));
      if (r < 3) ms_clock = $urandom;
      else ms_clock += $urandom_range(0, 12);
      if (r < 4) begin
        if ($urandom_range(0, 1)) aim[a] = pdc_pkg::SAMPLE_W'($urandom_range(0, SMAX));
        add_beat(MODE_CENTER, a, int'(aim[a]), ms_clock);
      end else if (r < 12) begin
        add_beat(MODE_SAMPLE, a, int'($urandom_range(0, SMAX)), ms_clock);
      end else begin
        span = (int'(c_stol) / 2 < int'(c_ctol)) ? int'(c_stol) / 2 : int'(c_ctol);
        v = int'(aim[a]) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        if (v > SMAX) v = SMAX;
        add_beat(MODE_SAMPLE, a, v, ms_clock);
      end
    end
  endtask

  initial begin
    for (int a = 0; a < pdc_pkg::AXES; a++) begin
      restart_axis(a, '0);
      m_center[a] = '0;
      m_held[a]   = '0;
    end
    m_armed = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values; first sample arrives before any center
    add_beat(MODE_SAMPLE, 0, 0, 0);
    add_beat(MODE_CENTER, 7, SMAX, 5);
    add_beat(MODE_CENTER, 7, SMAX, 6);
    add_beat(MODE_SAMPLE, 7, SMAX, 7);
    add_beat(MODE_SAMPLE, 7, 1000, 8);
    add_beat(MODE_SAMPLE, 7, SMAX, 2000);
    drain();

    // zero point count commits every stable sample
    set_regs(int'(pdc_pkg::CENTER_TOL_RST), int'(pdc_pkg::SPREAD_TOL_RST), 0, 0);
    add_beat(MODE_CENTER, 3, 512, 100);
    add_beat(MODE_SAMPLE, 3, 500, 101);
    add_beat(MODE_CENTER, 3, 512, 102);
    add_beat(MODE_SAMPLE, 3, 532, 103);
    add_beat(MODE_SAMPLE, 3, 533, 104);
    drain();

    // zero tolerances, window timing across the 32-bit wrap
    set_regs(0, 0, 'h200, 2);
    add_beat(MODE_CENTER, 1, 0, 32'hFFFF_FF00);
    add_beat(MODE_SAMPLE, 1, 0, 32'hFFFF_FFF0);
    add_beat(MODE_SAMPLE, 1, 0, 32'h0000_0100);
    add_beat(MODE_SAMPLE, 1, 0, 32'h0000_0101);
    add_beat(MODE_SAMPLE, 1, 1, 32'h0000_0102);
    drain();

    // widest tolerances and longest wait
    set_regs(SMAX, SMAX, 65535, 1023);
    add_beat(MODE_CENTER, 0, 0, 0);
    add_beat(MODE_SAMPLE, 0, SMAX, 1);
    add_beat(MODE_SAMPLE, 0, 0, 2);
    add_beat(MODE_CENTER, 0, SMAX, 3);
    add_beat(MODE_SAMPLE, 0, 0, 4);
    drain();

    // commits of a zero and of a negative full-scale offset
    set_regs(SMAX, SMAX, 0, 1);
    add_beat(MODE_SAMPLE, 0, SMAX, 5);
    add_beat(MODE_CENTER, 2, 0, 6);
    add_beat(MODE_SAMPLE, 2, SMAX, 7);
    drain();

    ms_clock = 5000;
    set_regs(20, 10, 0, 4);
    fill_random(100);
    drain();

    pace_on = 1'b0;
    set_regs(SMAX, SMAX, 0, 0);
    fill_random(100);
    drain();
    pace_on = 1'b1;

    set_regs(0, 0, 3, 1);
    fill_random(100);
    drain();

    ms_clock = 32'hFFFF_FF80;
    set_regs(40, 20, 30, 8);
    fill_random(100);
    drain();

    set_regs(SMAX, 0, 65535, 1023);
    fill_random(100);
    drain();

    set_regs(int'($urandom_range(5, 60)), int'($urandom_range(2, 30)),
             int'($urandom_range(0, 50)), int'($urandom_range(0, 12)));
    fill_random(100);
    drain();

    $display("%0d beats under %0d register writes: %0d results checked, %0d commits",
             n_beats, n_writes, n_results, n_commits);
    $display("%0d samples fell outside the tolerances", n_unstable);
    if (errors == 0)
      $display("tb_per_axis_drift_compensator OK");
    else
      $display("tb_per_axis_drift_compensator NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/pdc_pkg.sv
rtl/core/pdc_div.sv
rtl/core/pdc_ctrl.sv
rtl/core/pdc_datapath.sv
rtl/core/per_axis_drift_compensator.sv
verif/tb_per_axis_drift_compensator.sv
